FILE: rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the session data segmenter
// header octet table, request plan type and sizing constants
// ----------------------------------------------------------------------------
package sds_pkg;

   localparam int DEF_LENGTH_BITS = 24;   // ssdu length counter width
   localparam int MAX_LENGTH_BITS = 32;
   localparam int LEN_PORT_BITS   = 24;   // width of the length field on the port

   localparam int LIMIT_BITS      = 16;
   localparam logic [LIMIT_BITS-1:0] LIMIT_FLOOR     = 16'd8;
   localparam logic [LIMIT_BITS-1:0] SEG_HDR_OVERHEAD = 16'd7;

   localparam logic [2:0] PLAIN_HDR_LEN = 3'd4;
   localparam logic [2:0] SEG_HDR_LEN   = 3'd7;

   // spdu octets
   localparam logic [7:0] SPDU_GT         = 8'h01;
   localparam logic [7:0] SPDU_ZERO_LI    = 8'h00;
   localparam logic [7:0] SPDU_DT         = 8'h01;
   localparam logic [7:0] SPDU_DT_LI_SEG  = 8'h03;
   localparam logic [7:0] ENC_ITEM_PI     = 8'd25;
   localparam logic [7:0] ENC_ITEM_LI     = 8'h01;

   localparam logic [1:0] ENC_FIRST = 2'b01;
   localparam logic [1:0] ENC_LAST  = 2'b10;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   typedef enum logic [1:0] {
      HDR_NONE,
      HDR_PLAIN,
      HDR_SEG
   } hdr_kind_type;

   // everything one request emits, in compact form
   typedef struct packed {
      hdr_kind_type hdr_kind;
      logic [1:0]   hdr_enc;
      logic         hdr_last;    // header closes the unit
      logic         has_data;
      logic [7:0]   data_byte;
      logic         data_last;   // data octet closes the unit
      logic         error;
   } plan_type;

   function automatic logic [2:0] hdr_length(input hdr_kind_type kind);
      logic [2:0] len;
      unique case (kind)
         HDR_PLAIN: len = PLAIN_HDR_LEN;
         HDR_SEG:   len = SEG_HDR_LEN;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] hdr_octet(input hdr_kind_type kind,
                                            input logic [2:0] pos,
                                            input logic [1:0] enc);
      logic [7:0] b;
      b = 8'h00;
      if (kind == HDR_SEG) begin
         case (pos)
            3'd0:    b = SPDU_GT;
            3'd1:    b = SPDU_ZERO_LI;
            3'd2:    b = SPDU_DT;
            3'd3:    b = SPDU_DT_LI_SEG;
            3'd4:    b = ENC_ITEM_PI;
            3'd5:    b = ENC_ITEM_LI;
            3'd6:    b = {6'd0, enc};
            default: b = 8'h00;
         endcase
      end else begin
         case (pos)
            3'd0:    b = SPDU_GT;
            3'd1:    b = SPDU_ZERO_LI;
            3'd2:    b = SPDU_DT;
            default: b = SPDU_ZERO_LI;
         endcase
      end
      return b;
   endfunction

endpackage

FILE: rtl/sds_planner.sv
// ----------------------------------------------------------------------------
// sds_planner: ssdu state and per-request plan
// decides header and data octets for one request, updates state on accept
// ----------------------------------------------------------------------------
module sds_planner import sds_pkg::*; #(
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     cmd,
   input  logic [LEN_PORT_BITS-1:0] ssdu_length,
   input  logic [7:0]               data_byte,
   input  logic [LIMIT_BITS-1:0]    segment_limit,
   output plan_type                 plan
);

   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic [LIMIT_BITS-1:0]  seg_left_ff, seg_left_in;
   logic                   open_ff, open_in;

   logic [MAX_LENGTH_BITS-1:0] len_wide;
   logic [LENGTH_BITS-1:0]     len_masked;
   logic [LENGTH_BITS-1:0]     base_len;      // length the header is sized from
   logic [LIMIT_BITS-1:0]      limit_eff;
   logic [LIMIT_BITS-1:0]      seg_max;
   logic [LENGTH_BITS-1:0]     seg_max_wide;
   logic                       fits;
   logic [LIMIT_BITS-1:0]      chunk;
   logic                       seg_on;
   logic [LIMIT_BITS-1:0]      seg_tmp;
   logic [LENGTH_BITS-1:0]     rem_dec;
   logic [LIMIT_BITS-1:0]      seg_dec;

   always_comb begin
      len_wide     = MAX_LENGTH_BITS'(ssdu_length);
      len_masked   = len_wide[LENGTH_BITS-1:0];
      seg_on       = (segment_limit != '0);
      limit_eff    = (segment_limit < LIMIT_FLOOR) ? LIMIT_FLOOR : segment_limit;
      seg_max      = limit_eff - SEG_HDR_OVERHEAD;
      seg_max_wide = LENGTH_BITS'(seg_max);
      base_len     = (cmd == CMD_START) ? len_masked : remaining_ff;
      fits         = (base_len <= seg_max_wide);
      chunk        = fits ? base_len[LIMIT_BITS-1:0] : seg_max;
   end

   always_comb begin
      plan          = '0;
      plan.hdr_kind = HDR_NONE;
      remaining_in  = remaining_ff;
      seg_left_in   = seg_left_ff;
      open_in       = open_ff;
      seg_tmp       = seg_left_ff;
      rem_dec       = remaining_ff - 1'b1;
      seg_dec       = '0;

      if (cmd == CMD_START) begin
         remaining_in = len_masked;
         open_in      = (len_masked != '0);
         if (!seg_on) begin
            plan.hdr_kind = HDR_PLAIN;
            plan.hdr_last = (len_masked == '0);
            seg_left_in   = '0;
         end else begin
            plan.hdr_kind = HDR_SEG;
            plan.hdr_enc  = ENC_FIRST | (fits ? ENC_LAST : 2'b00);
            plan.hdr_last = (chunk == '0);
            seg_left_in   = chunk;
         end
      end else if (!open_ff) begin
         // stray byte: one error result, state untouched
         plan.has_data = 1'b1;
         plan.error    = 1'b1;
      end else begin
         if (seg_on && seg_left_ff == '0) begin
            plan.hdr_kind = HDR_SEG;
            plan.hdr_enc  = fits ? ENC_LAST : 2'b00;
            plan.hdr_last = (chunk == '0);
            seg_tmp       = chunk;
         end
         seg_dec        = (seg_tmp != '0) ? seg_tmp - 1'b1 : '0;
         plan.has_data  = 1'b1;
         plan.data_byte = data_byte;
         plan.data_last = (rem_dec == '0) || (seg_on && seg_dec == '0);
         remaining_in   = rem_dec;
         seg_left_in    = seg_dec;
         if (rem_dec == '0) begin
            open_in     = 1'b0;
            seg_left_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         seg_left_ff  <= '0;
         open_ff      <= 1'b0;
      end else if (accept) begin
         remaining_ff <= remaining_in;
         seg_left_ff  <= seg_left_in;
         open_ff      <= open_in;
      end
   end

endmodule

FILE: rtl/sds_emitter.sv
// ----------------------------------------------------------------------------
// sds_emitter: plan register and result register
// steps through the header octets and the data octet of one plan
// ----------------------------------------------------------------------------
module sds_emitter import sds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,        // request accepted, plan is valid
   input  plan_type   plan,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_unit_last,
   output logic       rsp_run_last,
   output logic       rsp_error
);

   plan_type   plan_ff;
   logic       plan_valid_ff;
   logic [2:0] pos_ff;

   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       unit_last_ff, unit_last_in;
   logic       run_last_ff, run_last_in;
   logic       error_ff, error_in;

   logic [2:0] hdr_len;
   logic       in_hdr;
   logic       hdr_end;
   logic       elem_last;
   logic       out_load;

   always_comb begin
      hdr_len   = hdr_length(plan_ff.hdr_kind);
      in_hdr    = (pos_ff < hdr_len);
      hdr_end   = (pos_ff == hdr_len - 3'd1);
      elem_last = in_hdr ? (hdr_end && !plan_ff.has_data) : 1'b1;
      out_load  = plan_valid_ff && (!rsp_valid_ff || !rsp_stall);
      ready     = !plan_valid_ff || (out_load && elem_last);

      if (in_hdr) begin
         out_byte_in  = hdr_octet(plan_ff.hdr_kind, pos_ff, plan_ff.hdr_enc);
         unit_last_in = hdr_end && plan_ff.hdr_last;
         error_in     = 1'b0;
      end else begin
         out_byte_in  = plan_ff.error ? 8'h00 : plan_ff.data_byte;
         unit_last_in = plan_ff.data_last && !plan_ff.error;
         error_in     = plan_ff.error;
      end
      run_last_in = elem_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         pos_ff        <= '0;
      end else if (load) begin
         plan_valid_ff <= 1'b1;
         pos_ff        <= '0;
      end else if (out_load && elem_last) begin
         plan_valid_ff <= 1'b0;
         pos_ff        <= '0;
      end else if (out_load) begin
         pos_ff <= pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         plan_ff <= plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff  <= out_byte_in;
         unit_last_ff <= unit_last_in;
         run_last_ff  <= run_last_in;
         error_ff     <= error_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_unit_last = unit_last_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_error     = error_ff;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && error_ff) |-> (run_last_ff && !unit_last_ff && out_byte_ff == 8'h00))
      else $error("malformed error result");

   a_no_hdr_pos: assert property (@(posedge clock) disable iff (reset)
      (plan_valid_ff && plan_ff.hdr_kind == HDR_NONE) |-> (pos_ff == 3'd0))
      else $error("octet position moved without a header");

   a_plain_pos: assert property (@(posedge clock) disable iff (reset)
      (plan_valid_ff && plan_ff.hdr_kind == HDR_PLAIN) |-> (pos_ff < PLAIN_HDR_LEN))
      else $error("octet position beyond plain header");

endmodule

FILE: rtl/session_data_segmenter.sv
// ----------------------------------------------------------------------------
// session_data_segmenter: frames session data units into transport units
// gt + dt spdu framing, optional segmenting with an enclosure item
// ----------------------------------------------------------------------------
// usage
//   csr_write_en / csr_segment_limit set the maximum unit size (0 = no
//   segmenting, 1..7 act as 8); write it only while the block is idle
//   req_*: one request is a start (req_cmd 0, req_ssdu_length) or one
//   payload octet (req_cmd 1, req_data_byte); taken when req_valid is high
//   and req_stall is low
//   rsp_*: one octet per result; rsp_unit_last closes a transport unit,
//   rsp_run_last marks the final result of a request, rsp_error flags a
//   payload octet with no ssdu open
// timing
//   a request is planned in the cycle it is taken and then passes the plan
//   register and the result register; it emits 1, 4, 7 or 8 results, one
//   per cycle while rsp_stall is low, set by the single result register
//   payload octets in a segment sustain one request per cycle while rsp_stall
//   is low; a start or a segment boundary holds off the next request
// reset
//   synchronous; closes any open ssdu, clears the limit and drops results
// stall
//   a stalled result holds; the plan register keeps the next request and
//   req_stall stays high until the plan register is drained
// ----------------------------------------------------------------------------
module session_data_segmenter import sds_pkg::*; #(
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_en,
   input  logic [LIMIT_BITS-1:0]    csr_segment_limit,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [LEN_PORT_BITS-1:0] req_ssdu_length,
   input  logic [7:0]               req_data_byte,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_unit_last,
   output logic                     rsp_run_last,
   output logic                     rsp_error
);

   // negotiated limit register
   logic [LIMIT_BITS-1:0] limit_ff;

   logic     ready;
   logic     accept;
   plan_type plan;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_write_en) begin
         limit_ff <= csr_segment_limit;
      end
   end

   // a request is taken whenever the plan register frees up this cycle
   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   sds_planner #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_planner (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cmd           (req_cmd),
      .ssdu_length   (req_ssdu_length),
      .data_byte     (req_data_byte),
      .segment_limit (limit_ff),
      .plan          (plan)
   );

   sds_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .plan          (plan),
      .ready         (ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_unit_last (rsp_unit_last),
      .rsp_run_last  (rsp_run_last),
      .rsp_error     (rsp_error)
   );

endmodule
